>>> rtl/core/clfbc_pkg.sv
// Shared types, register codes and the helper function of the byte cipher core.
package clfbc_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_DECRYPT_MODE = 2'd0,
    REG_TABLE_COUNT  = 2'd1,
    REG_SEED_LOW     = 2'd2,
    REG_SEED_HIGH    = 2'd3
  } cfg_reg_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Dictionary layout: decrypt half bit, table number, entry.
  localparam int DICT_ADDR_W = 17;
  localparam int DICT_DEPTH  = 131072;
  localparam int MAX_TABLES  = 256;

  // Remainder table: one entry per possible seed byte.
  localparam int MOD_DEPTH = 256;

  // Word kinds carried on in_tuser.
  localparam logic MODE_DICT_WRITE = 1'b0;
  localparam logic MODE_DATA       = 1'b1;

  // Fold a sum to a byte: low byte plus next byte, modulo 256.
  function automatic logic [7:0] fold_sum(input logic [15:0] sum);
    return sum[7:0] + sum[15:8];
  endfunction

endpackage

>>> rtl/core/clfbc_ram.sv
// Generic single-port synchronous RAM with a registered read.
module clfbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write takes the port; otherwise an enabled cycle reads, and the data holds.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rd_data_r <= mem_r[addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/chained_lookup_feedback_byte_cipher_core.sv
// Top level of the chained-lookup byte stream cipher with ciphertext feedback.
//
// A word with in_tuser low writes one dictionary byte and leaves the block
// ready for the next word. A word with in_tuser high encrypts or decrypts one
// byte: the block walks WINDOW_BYTES chained dictionary lookups, each passing
// through S_DICT and S_MODRD because the next dictionary address needs the
// previous seed looked up in the dictionary RAM and then reduced through the
// remainder RAM, each with a registered read. A new data word is only taken
// once the block has finished the previous one. The first data word after reset
// or a seed write first sums the window in S_SUM; after that the
// window sum is kept up to date as bytes are pushed. After reset and after
// every table_count write the block fills the 256-entry remainder table, one
// entry a cycle, and holds in_tready low until the table is full; configuration
// writes are still taken. The finished byte sits in an output register, so a
// new word is taken while the previous result waits.
module chained_lookup_feedback_byte_cipher_core
  import clfbc_pkg::*;
#(
  parameter int WINDOW_BYTES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input words.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [16:0] table_address, [24:17] table_byte, [32:25] data_byte, [39:33] zero
  input  logic [39:0]           in_tdata,
  // [0] mode
  input  logic                  in_tuser,
  // Result words.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] out_byte
  output logic [7:0]            out_tdata,
  // Configuration writes.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
  localparam int K_W   = $clog2(WINDOW_BYTES + 1);
  localparam int SUM_W = $clog2(WINDOW_BYTES * 255 + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_BYTES - 1);
  localparam logic [K_W-1:0]   LAST_K   = K_W'(WINDOW_BYTES - 1);
  localparam logic [K_W-1:0]   FINAL_K  = K_W'(WINDOW_BYTES);

  typedef enum logic [7:0] {
    S_SWEEP = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SUM   = 8'b0000_0100,
    S_SEED  = 8'b0000_1000,
    S_DICT  = 8'b0001_0000,
    S_MODRD = 8'b0010_0000,
    S_FINAL = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    decrypt_r, decrypt_nxt;
  logic [8:0]              tcount_r, tcount_nxt;
  logic [CFG_DATA_W-1:0]   seed_low_r, seed_low_nxt;
  logic [CFG_DATA_W-1:0]   seed_high_r, seed_high_nxt;
  logic [7:0]              win_r [WINDOW_BYTES];
  logic [7:0]              win_nxt [WINDOW_BYTES];
  logic [IDX_W-1:0]        oldest_r, oldest_nxt;
  logic                    sum_valid_r, sum_valid_nxt;
  logic [SUM_W-1:0]        win_sum_r, win_sum_nxt;
  logic [SUM_W-1:0]        look_sum_r, look_sum_nxt;
  logic [IDX_W-1:0]        pos_r, pos_nxt;
  logic [K_W-1:0]          k_r, k_nxt;
  logic [7:0]              data_r, data_nxt;
  logic [7:0]              sweep_cnt_r, sweep_cnt_nxt;
  logic [7:0]              rem_r, rem_nxt;
  logic [7:0]              res_r, res_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [7:0]              out_tdata_r, out_tdata_nxt;

  // Memory ports.
  logic                    mod_en, mod_we;
  logic [7:0]              mod_addr, mod_wdata, mod_q;
  logic                    dict_en, dict_we;
  logic [DICT_ADDR_W-1:0]  dict_addr;
  logic [7:0]              dict_wdata, dict_q;

  // Helper values.
  logic                    in_fire;
  logic [8:0]              eff_count;
  logic [8:0]              rem_inc;
  logic [IDX_W-1:0]        pos_inc;
  logic [7:0]              win_byte;
  logic [7:0]              cipher;
  logic                    final_lookup;
  logic                    out_free;
  logic [CFG_DATA_W-1:0]   new_low, new_high;
  logic [2*CFG_DATA_W-1:0] seed_cat;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_free   = !out_tvalid_r || out_tready;

  // A count of zero or above the table limit means all tables.
  assign eff_count = (tcount_r == 9'd0 || tcount_r > 9'(MAX_TABLES)) ?
                     9'(MAX_TABLES) : tcount_r;
  assign rem_inc   = {1'b0, rem_r} + 9'd1;
  assign pos_inc   = (pos_r == LAST_IDX) ? '0 : pos_r + IDX_W'(1);
  assign win_byte  = win_r[pos_r];
  assign final_lookup = (k_r == FINAL_K);
  assign cipher    = decrypt_r ? data_r : dict_q;

  // Remainder table: entry s holds s modulo the effective table count.
  clfbc_ram #(
    .WIDTH (8),
    .DEPTH (MOD_DEPTH)
  ) u_mod_ram (
    .clk     (clk),
    .en      (mod_en),
    .we      (mod_we),
    .addr    (mod_addr),
    .wdata   (mod_wdata),
    .rd_data (mod_q)
  );

  // Dictionary: encrypt tables in the lower half, decrypt tables in the upper.
  clfbc_ram #(
    .WIDTH (8),
    .DEPTH (DICT_DEPTH)
  ) u_dict_ram (
    .clk     (clk),
    .en      (dict_en),
    .we      (dict_we),
    .addr    (dict_addr),
    .wdata   (dict_wdata),
    .rd_data (dict_q)
  );

  // Sequencer, memory port control and configuration writes.
  always_comb begin
    state_nxt      = state_r;
    decrypt_nxt    = decrypt_r;
    tcount_nxt     = tcount_r;
    seed_low_nxt   = seed_low_r;
    seed_high_nxt  = seed_high_r;
    win_nxt        = win_r;
    oldest_nxt     = oldest_r;
    sum_valid_nxt  = sum_valid_r;
    win_sum_nxt    = win_sum_r;
    look_sum_nxt   = look_sum_r;
    pos_nxt        = pos_r;
    k_nxt          = k_r;
    data_nxt       = data_r;
    sweep_cnt_nxt  = sweep_cnt_r;
    rem_nxt        = rem_r;
    res_nxt        = res_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    new_low        = seed_low_r;
    new_high       = seed_high_r;
    seed_cat       = '0;

    mod_en     = 1'b0;
    mod_we     = 1'b0;
    mod_addr   = sweep_cnt_r;
    mod_wdata  = rem_r;
    dict_en    = 1'b0;
    dict_we    = 1'b0;
    dict_addr  = in_tdata[16:0];
    dict_wdata = in_tdata[24:17];

    unique case (state_r)
      S_SWEEP: begin
        mod_en        = 1'b1;
        mod_we        = 1'b1;
        sweep_cnt_nxt = sweep_cnt_r + 8'd1;
        rem_nxt       = (rem_inc == eff_count) ? 8'd0 : rem_inc[7:0];
        if (sweep_cnt_r == 8'(MOD_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser == MODE_DICT_WRITE) begin
            dict_en = 1'b1;
            dict_we = 1'b1;
          end else begin
            data_nxt = in_tdata[32:25];
            if (sum_valid_r) begin
              state_nxt = S_SEED;
            end else begin
              win_sum_nxt = '0;
              pos_nxt     = '0;
              k_nxt       = '0;
              state_nxt   = S_SUM;
            end
          end
        end
      end

      // Sum the reloaded window one byte a cycle.
      S_SUM: begin
        win_sum_nxt = win_sum_r + SUM_W'(win_byte);
        pos_nxt     = pos_inc;
        k_nxt       = k_r + K_W'(1);
        if (k_r == LAST_K) begin
          sum_valid_nxt = 1'b1;
          state_nxt     = S_SEED;
        end
      end

      // Reduce the folded window sum to a table number.
      S_SEED: begin
        mod_en       = 1'b1;
        mod_addr     = fold_sum(16'(win_sum_r));
        pos_nxt      = oldest_r;
        k_nxt        = '0;
        look_sum_nxt = '0;
        state_nxt    = S_DICT;
      end

      // Table number is ready: read the dictionary.
      S_DICT: begin
        dict_en   = 1'b1;
        dict_addr = {final_lookup && decrypt_r, mod_q,
                     final_lookup ? data_r : win_byte};
        state_nxt = final_lookup ? S_FINAL : S_MODRD;
      end

      // Looked-up byte is the next seed; reduce it (last step: folded sum of looked-up bytes) to a table number.
      S_MODRD: begin
        look_sum_nxt = look_sum_r + SUM_W'(dict_q);
        mod_en       = 1'b1;
        mod_addr     = (k_r == LAST_K) ? fold_sum(16'(look_sum_nxt)) : dict_q;
        k_nxt        = k_r + K_W'(1);
        pos_nxt      = pos_inc;
        state_nxt    = S_DICT;
      end

      // Result is read; push the ciphertext byte over the oldest one.
      S_FINAL: begin
        res_nxt          = dict_q;
        win_nxt[pos_r]   = cipher;
        win_sum_nxt      = win_sum_r - SUM_W'(win_byte) + SUM_W'(cipher);
        oldest_nxt       = pos_inc;
        state_nxt        = S_OUT;
      end

      S_OUT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = res_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Configuration writes must arrive only while the block is idle or filling; the block itself does not enforce this.
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DECRYPT_MODE: begin
          decrypt_nxt = cfg_wdata[0];
        end
        REG_TABLE_COUNT: begin
          tcount_nxt    = cfg_wdata[8:0];
          sweep_cnt_nxt = '0;
          rem_nxt       = '0;
          state_nxt     = S_SWEEP;
        end
        REG_SEED_LOW: begin
          new_low      = cfg_wdata;
          seed_low_nxt = cfg_wdata;
        end
        REG_SEED_HIGH: begin
          new_high      = cfg_wdata;
          seed_high_nxt = cfg_wdata;
        end
        default: begin
        end
      endcase

      // A seed write reloads the whole window; bytes past the seeds load zero.
      if (cfg_index == REG_SEED_LOW || cfg_index == REG_SEED_HIGH) begin
        seed_cat = {new_high, new_low};
        for (int i = 0; i < WINDOW_BYTES; i++) begin
          win_nxt[i] = 8'(seed_cat >> (8 * i));
        end
        oldest_nxt    = '0;
        sum_valid_nxt = 1'b0;
      end
    end
  end

  // Control and window state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      decrypt_r    <= 1'b0;
      tcount_r     <= 9'(MAX_TABLES);
      seed_low_r   <= '0;
      seed_high_r  <= '0;
      for (int i = 0; i < WINDOW_BYTES; i++) begin
        win_r[i] <= '0;
      end
      oldest_r     <= '0;
      sum_valid_r  <= 1'b0;
      sweep_cnt_r  <= '0;
      rem_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      decrypt_r    <= decrypt_nxt;
      tcount_r     <= tcount_nxt;
      seed_low_r   <= seed_low_nxt;
      seed_high_r  <= seed_high_nxt;
      win_r        <= win_nxt;
      oldest_r     <= oldest_nxt;
      sum_valid_r  <= sum_valid_nxt;
      sweep_cnt_r  <= sweep_cnt_nxt;
      rem_r        <= rem_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    win_sum_r   <= win_sum_nxt;
    look_sum_r  <= look_sum_nxt;
    pos_r       <= pos_nxt;
    k_r         <= k_nxt;
    data_r      <= data_nxt;
    res_r       <= res_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule

>>> rtl/core/clfbc_checker.sv
// Port-level checker for the byte cipher core and its bind to the top level.
module clfbc_checker
  import clfbc_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 in_tuser,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [7:0]           out_tdata,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index
);

  // Nothing is offered on the result side right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word offered right after reset");

  // A stalled result word stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word dropped or changed");

  // A data word keeps the block busy in the following cycle.
  a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == MODE_DATA |=> !in_tready)
    else $error("input taken again right after a data word");

  // A table count write starts the remainder table fill.
  a_count_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == REG_TABLE_COUNT |=> !in_tready)
    else $error("input ready right after a table count write");

  // A dictionary write leaves the block ready for the next word.
  a_dict_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == MODE_DICT_WRITE && !cfg_we |=> in_tready)
    else $error("dictionary write left the input stalled");

endmodule

bind chained_lookup_feedback_byte_cipher_core clfbc_checker u_clfbc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_we     (cfg_we),
  .cfg_index  (cfg_index)
);
